@@ hw/rtl/sctag_pkg.sv @@
// Shared types and constants of the sector cache tag store.
// Used by sctag_ctrl, sctag_dp and sector_cache_tag_store; no dependencies.
package sctag_pkg;

    localparam int ACT_W  = 3;
    localparam int DEV_W  = 16;
    localparam int SEC_W  = 48;
    localparam int SIDX_W = 8;
    localparam int SLOT_W = 11;
    localparam int ENT_W  = 2 + DEV_W + SEC_W;
    localparam int HASH_W = 64;

    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;
    localparam int MCNT_W    = $clog2(MOD_STEPS);

    localparam logic [30:0] HASH_DEV_MUL = 31'd1103515245;
    localparam logic [32:0] HASH_SEC_MUL = 33'd5838519855;

    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_CLN = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_DTY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MARK    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FLUSH_E = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FLUSH_S = 3'd5;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_WB   = 1'b1;

    typedef struct packed {
        logic clr;
        logic load;
        logic prod;
        logic mix;
        logic mod_step;
        logic rd;
        logic eval;
        logic emit_wb;
        logic emit_done;
    } sctag_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic wb_pend;
        logic out_free;
    } sctag_stat_t;

endpackage

@@ hw/rtl/sctag_ctrl.sv @@
// Controller of the sector cache tag store: sequences clear, hash, read,
// writebacks and completion. Depends on sctag_pkg.
module sctag_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sctag_pkg::sctag_stat_t stat,
    output sctag_pkg::sctag_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_PROD, ST_MIX, ST_MOD, ST_RD, ST_EVAL, ST_WB, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last) state_next = ST_RD;
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                if (!stat.wb_pend) begin
                    state_next = ST_DONE;
                end else if (stat.out_free) begin
                    cmd.emit_wb = 1'b1;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

endmodule

@@ hw/rtl/sctag_dp.sv @@
// Datapath of the sector cache tag store: request registers, set hash,
// remainder unit, tag memory (one row per set) and output register. Depends on sctag_pkg.
module sctag_dp #(
    parameter int SETS = 256,
    parameter int WAYS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sctag_pkg::sctag_cmd_t             cmd,
    output sctag_pkg::sctag_stat_t            stat,
    input  logic [sctag_pkg::ACT_W-1:0]       s_action,
    input  logic [sctag_pkg::DEV_W-1:0]       s_device,
    input  logic [sctag_pkg::SEC_W-1:0]       s_sector,
    input  logic [sctag_pkg::SIDX_W-1:0]      s_set_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic                              m_hit,
    output logic [sctag_pkg::DEV_W-1:0]       m_out_device,
    output logic [sctag_pkg::SEC_W-1:0]       m_out_sector,
    output logic [sctag_pkg::SLOT_W-1:0]      m_slot,
    output logic                              m_last
);

    localparam int  SET_W  = $clog2(SETS);
    localparam int  WAY_W  = $clog2(WAYS);
    localparam int  FILL_W = $clog2(WAYS + 1);
    localparam int  BASE_W = $clog2(SETS * WAYS);
    localparam int  META_W = WAY_W + FILL_W;
    localparam int  ROW_W  = WAYS * sctag_pkg::ENT_W + META_W;
    localparam bit  POW2   = ((SETS & (SETS - 1)) == 0);
    localparam logic [SET_W:0] SETS_C = (SET_W + 1)'(SETS);

    // request
    logic [sctag_pkg::ACT_W-1:0]  act_reg;
    logic [sctag_pkg::DEV_W-1:0]  dev_reg;
    logic [sctag_pkg::SEC_W-1:0]  sec_reg;
    logic [sctag_pkg::SIDX_W-1:0] sidx_reg;

    // hash and remainder
    logic [46:0]                  pdev_reg;
    logic [63:0]                  plo_reg;
    logic [31:0]                  phi_reg;
    logic [sctag_pkg::HASH_W-1:0] val_reg;
    logic [SET_W-1:0]             rem_reg, rem_next;
    logic [sctag_pkg::MCNT_W-1:0] mcnt_reg;
    logic [SET_W-1:0]             set_w, set_reg;
    logic [BASE_W-1:0]            base_reg;
    logic [sctag_pkg::HASH_W-1:0] hash_w;

    // memory
    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rd_row_reg, new_row, new_row_reg;
    logic [SET_W-1:0] clr_cnt_reg;

    // plan
    logic [WAYS-1:0]               wb_mask, wb_mask_reg;
    logic                          dn_hit, dn_hit_reg;
    logic [sctag_pkg::SLOT_W-1:0]  dn_slot, dn_slot_reg;
    logic [sctag_pkg::DEV_W-1:0]   dn_dev, dn_dev_reg;
    logic [sctag_pkg::SEC_W-1:0]   dn_sec, dn_sec_reg;

    // output register
    logic                          m_valid_reg;
    logic                          m_kind_reg, m_hit_reg, m_last_reg;
    logic [sctag_pkg::DEV_W-1:0]   m_dev_reg;
    logic [sctag_pkg::SEC_W-1:0]   m_sec_reg;
    logic [sctag_pkg::SLOT_W-1:0]  m_slot_reg;

    // row fields
    logic                          e_valid [WAYS];
    logic                          e_dirty [WAYS];
    logic [sctag_pkg::DEV_W-1:0]   e_dev   [WAYS];
    logic [sctag_pkg::SEC_W-1:0]   e_sec   [WAYS];
    logic                          n_valid [WAYS];
    logic                          n_dirty [WAYS];
    logic [sctag_pkg::DEV_W-1:0]   n_dev   [WAYS];
    logic [sctag_pkg::SEC_W-1:0]   n_sec   [WAYS];
    logic [WAY_W-1:0]              oldest, n_oldest;
    logic [FILL_W-1:0]             fill, n_fill;
    logic                          hit_any;
    logic [WAY_W-1:0]              hit_way, idx, wb_way;
    logic [WAY_W:0]                ring;
    logic                          out_free;

    assign hash_w = {17'd0, pdev_reg} ^ (plo_reg + {phi_reg, 32'd0});
    assign set_w  = POW2 ? val_reg[SET_W-1:0] : rem_reg;

    always_comb begin
        logic [SET_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < sctag_pkg::MOD_BITS; i++) begin
            t = {rem_next, val_reg[sctag_pkg::HASH_W-1-i]};
            if (t >= SETS_C) t = t - SETS_C;
            rem_next = t[SET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            dev_reg  <= s_device;
            sec_reg  <= s_sector;
            sidx_reg <= s_set_index;
        end
        if (cmd.prod) begin
            pdev_reg <= dev_reg * sctag_pkg::HASH_DEV_MUL;
            plo_reg  <= 64'(sec_reg[31:0] * sctag_pkg::HASH_SEC_MUL);
            phi_reg  <= 32'(sec_reg[47:32] * sctag_pkg::HASH_SEC_MUL);
        end
        if (cmd.mix) begin
            val_reg <= (act_reg == sctag_pkg::ACT_FLUSH_S) ?
                       sctag_pkg::HASH_W'(sidx_reg) : hash_w;
            rem_reg <= '0;
        end else if (cmd.mod_step && !POW2) begin
            val_reg <= val_reg << sctag_pkg::MOD_BITS;
            rem_reg <= rem_next;
        end
        if (cmd.rd) begin
            set_reg  <= set_w;
            base_reg <= BASE_W'(set_w * WAYS);
        end
        if (cmd.eval) begin
            new_row_reg <= new_row;
            dn_hit_reg  <= dn_hit;
            dn_slot_reg <= dn_slot;
            dn_dev_reg  <= dn_dev;
            dn_sec_reg  <= dn_sec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcnt_reg    <= '0;
            clr_cnt_reg <= '0;
            wb_mask_reg <= '0;
        end else begin
            if (cmd.mix) mcnt_reg <= '0;
            else if (cmd.mod_step) mcnt_reg <= mcnt_reg + 1'b1;
            if (cmd.clr) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.eval) wb_mask_reg <= wb_mask;
            else if (cmd.emit_wb) wb_mask_reg <= wb_mask_reg & (wb_mask_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.emit_done) begin
            mem[set_reg] <= new_row_reg;
        end
        if (cmd.rd) rd_row_reg <= mem[set_w];
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            {e_valid[w], e_dirty[w], e_dev[w], e_sec[w]} =
                rd_row_reg[w*sctag_pkg::ENT_W +: sctag_pkg::ENT_W];
        end
        {oldest, fill} = rd_row_reg[WAYS*sctag_pkg::ENT_W +: META_W];
    end

    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (e_valid[w] && e_dev[w] == dev_reg && e_sec[w] == sec_reg) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        ring = {1'b0, oldest} + (WAY_W + 1)'(fill);
        if (ring >= (WAY_W + 1)'(WAYS)) ring = ring - (WAY_W + 1)'(WAYS);
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            n_valid[w] = e_valid[w];
            n_dirty[w] = e_dirty[w];
            n_dev[w]   = e_dev[w];
            n_sec[w]   = e_sec[w];
        end
        n_oldest = oldest;
        n_fill   = fill;
        wb_mask  = '0;
        idx      = hit_way;
        dn_hit   = 1'b0;
        dn_slot  = '0;
        dn_dev   = dev_reg;
        dn_sec   = sec_reg;
        case (act_reg)
            sctag_pkg::ACT_LOOKUP: begin
                if (hit_any) begin
                    dn_hit  = 1'b1;
                    dn_slot = sctag_pkg::SLOT_W'(base_reg + BASE_W'(hit_way));
                end
            end
            sctag_pkg::ACT_INS_CLN, sctag_pkg::ACT_INS_DTY: begin
                if (hit_any) begin
                    idx = hit_way;
                    wb_mask[hit_way] = e_dirty[hit_way];
                end else if (fill < FILL_W'(WAYS)) begin
                    idx    = ring[WAY_W-1:0];
                    n_fill = fill + 1'b1;
                end else begin
                    idx = oldest;
                    wb_mask[oldest] = e_valid[oldest] && e_dirty[oldest];
                    n_oldest = (oldest == WAY_W'(WAYS - 1)) ? '0 : oldest + 1'b1;
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (idx == WAY_W'(w)) begin
                        n_valid[w] = 1'b1;
                        n_dirty[w] = (act_reg == sctag_pkg::ACT_INS_DTY);
                        n_dev[w]   = dev_reg;
                        n_sec[w]   = sec_reg;
                    end
                end
                dn_hit  = 1'b1;
                dn_slot = sctag_pkg::SLOT_W'(base_reg + BASE_W'(idx));
            end
            sctag_pkg::ACT_MARK: begin
                if (hit_any) begin
                    n_dirty[hit_way] = 1'b1;
                    dn_hit  = 1'b1;
                    dn_slot = sctag_pkg::SLOT_W'(base_reg + BASE_W'(hit_way));
                end
            end
            sctag_pkg::ACT_FLUSH_E: begin
                if (hit_any) begin
                    wb_mask[hit_way] = e_dirty[hit_way];
                    n_dirty[hit_way] = 1'b0;
                    dn_hit  = 1'b1;
                    dn_slot = sctag_pkg::SLOT_W'(base_reg + BASE_W'(hit_way));
                end
            end
            sctag_pkg::ACT_FLUSH_S: begin
                for (int w = 0; w < WAYS; w++) begin
                    wb_mask[w] = e_valid[w] && e_dirty[w];
                    n_dirty[w] = 1'b0;
                end
                dn_slot = sctag_pkg::SLOT_W'(base_reg);
                dn_dev  = '0;
                dn_sec  = '0;
            end
            default: ;
        endcase
        for (int w = 0; w < WAYS; w++) begin
            new_row[w*sctag_pkg::ENT_W +: sctag_pkg::ENT_W] =
                {n_valid[w], n_dirty[w], n_dev[w], n_sec[w]};
        end
        new_row[WAYS*sctag_pkg::ENT_W +: META_W] = {n_oldest, n_fill};
    end

    always_comb begin
        wb_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (wb_mask_reg[w]) wb_way = WAY_W'(w);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_wb || cmd.emit_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_wb) begin
            m_kind_reg <= sctag_pkg::KIND_WB;
            m_hit_reg  <= 1'b0;
            m_dev_reg  <= e_dev[wb_way];
            m_sec_reg  <= e_sec[wb_way];
            m_slot_reg <= sctag_pkg::SLOT_W'(base_reg + BASE_W'(wb_way));
            m_last_reg <= 1'b0;
        end else if (cmd.emit_done) begin
            m_kind_reg <= sctag_pkg::KIND_DONE;
            m_hit_reg  <= dn_hit_reg;
            m_dev_reg  <= dn_dev_reg;
            m_sec_reg  <= dn_sec_reg;
            m_slot_reg <= dn_slot_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign stat.clr_last = (clr_cnt_reg == SET_W'(SETS - 1));
    assign stat.mod_last = POW2 || (mcnt_reg == sctag_pkg::MCNT_W'(sctag_pkg::MOD_STEPS - 1));
    assign stat.wb_pend  = |wb_mask_reg;
    assign stat.out_free = out_free;

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_hit        = m_hit_reg;
    assign m_out_device = m_dev_reg;
    assign m_out_sector = m_sec_reg;
    assign m_slot       = m_slot_reg;
    assign m_last       = m_last_reg;

endmodule

@@ hw/rtl/sector_cache_tag_store.sv @@
// Top level of the sector cache tag store: controller plus datapath.
// Depends on sctag_pkg, sctag_ctrl and sctag_dp.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------
//  request | s_action s_device s_sector s_set_index       | s_valid/s_ready
//  result  | m_kind m_hit m_out_device m_out_sector m_slot m_last | m_valid/m_ready
//
// One request at a time. When SETS is a power of two the set is the low hash bits;
// otherwise 8 remainder steps of 8 bits each. Writeback results come before the completion.
// After reset a clearing pass writes every set row, with s_ready low.
// A stalled result holds in the output register; the next request is taken meanwhile.
module sector_cache_tag_store #(
    parameter int SETS = 256,
    parameter int WAYS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sctag_pkg::ACT_W-1:0]       s_action,
    input  logic [sctag_pkg::DEV_W-1:0]       s_device,
    input  logic [sctag_pkg::SEC_W-1:0]       s_sector,
    input  logic [sctag_pkg::SIDX_W-1:0]      s_set_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic                              m_hit,
    output logic [sctag_pkg::DEV_W-1:0]       m_out_device,
    output logic [sctag_pkg::SEC_W-1:0]       m_out_sector,
    output logic [sctag_pkg::SLOT_W-1:0]      m_slot,
    output logic                              m_last
);

    sctag_pkg::sctag_cmd_t  cmd;
    sctag_pkg::sctag_stat_t stat;

    sctag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sctag_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_action     (s_action),
        .s_device     (s_device),
        .s_sector     (s_sector),
        .s_set_index  (s_set_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_hit        (m_hit),
        .m_out_device (m_out_device),
        .m_out_sector (m_out_sector),
        .m_slot       (m_slot),
        .m_last       (m_last)
    );

endmodule
